// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for clocked checks, disabled while active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define MPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mpq check failed");

// Next-cycle implication
`define MPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mpq check failed");

`endif

// ----- rtl/core/mpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and constants for the array priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int ID_W      = 16;
  localparam int PRIO_W    = 8;
  localparam int BURST_W   = 16;
  localparam int OCC_W     = 4;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } rec_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_REMOVED   = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/max_priority_queue_array_unit.sv -----
// ----------------------------------------------------------------------------
// max_priority_queue_array_unit
// Insert: the record is written on accept, then S_DONE loads the result.
// Remove: one store read per cycle for the scan (S_SCAN) and one read/write
// per cycle to close the gap (S_SHIFT). Underflow and overflow skip the store.
// Input is held off until the result loads the output register.
// Synchronous reset empties the queue; stored records are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module max_priority_queue_array_unit
  import mpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_mode,
  input  wire logic [ID_W-1:0]     in_proc_id,
  input  wire logic [PRIO_W-1:0]   in_priority_req,
  input  wire logic [BURST_W-1:0]  in_burst_time,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_status,
  output logic [ID_W-1:0]          out_proc_id,
  output logic [PRIO_W-1:0]        out_priority,
  output logic [BURST_W-1:0]       out_burst_time,
  output logic [OCC_W-1:0]         out_occupancy
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CW1 = CW + 1;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   best_idx_r, best_idx_nxt;
  rec_t            best_r, best_nxt;
  status_t         status_r, status_nxt;

  logic            out_valid_r;
  status_t         out_status_r;
  rec_t            out_rec_r;
  logic [OCC_W-1:0] out_occ_r;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  rec_t            wr_data;
  logic [AW-1:0]   rd_addr;
  rec_t            rd_data;

  logic            out_free;
  logic            cand_better;
  rec_t            sel_rec;
  logic [CW-1:0]   sel_idx;
  logic [CW-1:0]   sel_idx_p1;
  logic [CW1-1:0]  shift_p2;

  mpq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign cand_better = (idx_r == CW'(1)) || (rd_data.prio > best_r.prio);
  assign sel_rec     = cand_better ? rd_data : best_r;
  assign sel_idx     = cand_better ? (idx_r - CW'(1)) : best_idx_r;
  assign sel_idx_p1  = sel_idx + CW'(1);
  assign shift_p2    = {1'b0, idx_r} + CW1'(2);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    status_nxt   = status_r;
    wr_en        = 1'b0;
    wr_addr      = count_r[AW-1:0];
    wr_data      = '{id: in_proc_id, prio: in_priority_req, burst: in_burst_time};
    rd_addr      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_mode) begin
            best_nxt  = '0;
            state_nxt = S_DONE;
            if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              wr_en      = 1'b1;
              count_nxt  = count_r + CW'(1);
              status_nxt = ST_INSERTED;
            end
          end else if (count_r == '0) begin
            best_nxt   = '0;
            status_nxt = ST_UNDERFLOW;
            state_nxt  = S_DONE;
          end else begin
            idx_nxt   = CW'(1);
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        best_nxt     = sel_rec;
        best_idx_nxt = sel_idx;
        if (idx_r != count_r) begin
          rd_addr = idx_r[AW-1:0];
          idx_nxt = idx_r + CW'(1);
        end else if (sel_idx_p1 < count_r) begin
          rd_addr   = sel_idx_p1[AW-1:0];
          idx_nxt   = sel_idx;
          state_nxt = S_SHIFT;
        end else begin
          count_nxt  = count_r - CW'(1);
          status_nxt = ST_REMOVED;
          state_nxt  = S_DONE;
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[AW-1:0];
        wr_data = rd_data;
        if (shift_p2 < {1'b0, count_r}) begin
          rd_addr = shift_p2[AW-1:0];
          idx_nxt = idx_r + CW'(1);
        end else begin
          count_nxt  = count_r - CW'(1);
          status_nxt = ST_REMOVED;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    status_r   <= status_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r <= status_r;
      out_rec_r    <= best_r;
      out_occ_r    <= OCC_W'(count_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_proc_id    = out_rec_r.id;
  assign out_priority   = out_rec_r.prio;
  assign out_burst_time = out_rec_r.burst;
  assign out_occupancy  = out_occ_r;

endmodule

`default_nettype wire

// ----- rtl/core/mpq_ram.sv -----
// ----------------------------------------------------------------------------
// mpq_ram
// Record store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_ram
  import mpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire rec_t          wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output rec_t               rd_data
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/mpq_checker.sv -----
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks for the array priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mpq_port_checker
  import mpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_status,
  input wire logic [ID_W-1:0]    out_proc_id,
  input wire logic [PRIO_W-1:0]  out_priority,
  input wire logic [BURST_W-1:0] out_burst_time,
  input wire logic [OCC_W-1:0]   out_occupancy
);

  `MPQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_status) && $stable(out_occupancy))

  `MPQ_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  `MPQ_ASSERT_IMP(a_zero_payload, clk, rst_n, out_valid && (out_status != ST_REMOVED),
    (out_proc_id == '0) && (out_priority == '0) && (out_burst_time == '0))

  `MPQ_ASSERT_IMP(a_overflow_full, clk, rst_n, out_valid && (out_status == ST_OVERFLOW),
    out_occupancy == OCC_W'(DEPTH))

  `MPQ_ASSERT_IMP(a_occ_bound, clk, rst_n, out_valid,
    (DEPTH > 15) || (out_occupancy <= OCC_W'(DEPTH)))

endmodule

bind max_priority_queue_array_unit mpq_port_checker #(
  .DEPTH (DEPTH)
) u_mpq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_proc_id    (out_proc_id),
  .out_priority   (out_priority),
  .out_burst_time (out_burst_time),
  .out_occupancy  (out_occupancy)
);

`default_nettype wire

// ----- tb/mpq_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpq_tb_pkg
// Request codes shared by the stimulus and the checker of the queue unit.
// ----------------------------------------------------------------------------

package mpq_tb_pkg;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } req_mode_t;

endpackage

// ----- tb/mpq_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpq_checker
// Watches the request and result channels of the queue unit, keeps its own
// copy of the record store and count, predicts the result of every accepted
// request and compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------

module mpq_checker
  import mpq_pkg::*;
  import mpq_tb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic               in_mode,
  input  wire logic [ID_W-1:0]    in_proc_id,
  input  wire logic [PRIO_W-1:0]  in_priority_req,
  input  wire logic [BURST_W-1:0] in_burst_time,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         out_status,
  input  wire logic [ID_W-1:0]    out_proc_id,
  input  wire logic [PRIO_W-1:0]  out_priority,
  input  wire logic [BURST_W-1:0] out_burst_time,
  input  wire logic [OCC_W-1:0]   out_occupancy,
  output int                      mismatch_count,
  output int                      results_pending
);

  typedef struct {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [OCC_W-1:0]   occ;
  } queue_result_t;

  rec_t          shadow_store [DEPTH];
  int            shadow_count;
  queue_result_t expected_results [$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
    shadow_count    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mpq_checker: %s got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  task automatic serve_request(input logic mode, input logic [ID_W-1:0] id,
                               input logic [PRIO_W-1:0] prio,
                               input logic [BURST_W-1:0] burst);
    queue_result_t r;
    int            best;
    int            k;
    r.status = ST_INSERTED;
    r.id     = '0;
    r.prio   = '0;
    r.burst  = '0;
    if (mode == MODE_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        shadow_store[shadow_count] = '{id: id, prio: prio, burst: burst};
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_UNDERFLOW;
    end else begin
      best = 0;
      for (k = 1; k < shadow_count; k++) begin
        if (shadow_store[k].prio > shadow_store[best].prio) best = k;
      end
      r.status = ST_REMOVED;
      r.id     = shadow_store[best].id;
      r.prio   = shadow_store[best].prio;
      r.burst  = shadow_store[best].burst;
      for (k = best; k + 1 < shadow_count; k++) begin
        shadow_store[k] = shadow_store[k + 1];
      end
      shadow_count--;
    end
    r.occ = shadow_count[OCC_W-1:0];
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        serve_request(in_mode, in_proc_id, in_priority_req, in_burst_time);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(out_status), 32'(0));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_proc_id !== want.id)
            report_mismatch("proc_id", 32'(out_proc_id), 32'(want.id));
          if (out_priority !== want.prio)
            report_mismatch("priority", 32'(out_priority), 32'(want.prio));
          if (out_burst_time !== want.burst)
            report_mismatch("burst_time", 32'(out_burst_time), 32'(want.burst));
          if (out_occupancy !== want.occ)
            report_mismatch("occupancy", 32'(out_occupancy), 32'(want.occ));
        end
      end
    end
    results_pending = expected_results.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the queue unit with directed requests (underflow, fill with extreme
// fields and ties, overflow, drain) and then random insert/remove mixes,
// with random idling on both sides, a quiet stretch and one long hold-off
// of the result side. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------

module tb_top;
  import mpq_pkg::*;
  import mpq_tb_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int RAND_ITEMS     = 1930;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode;
  logic [ID_W-1:0]    in_proc_id;
  logic [PRIO_W-1:0]  in_priority_req;
  logic [BURST_W-1:0] in_burst_time;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [ID_W-1:0]    out_proc_id;
  logic [PRIO_W-1:0]  out_priority;
  logic [BURST_W-1:0] out_burst_time;
  logic [OCC_W-1:0]   out_occupancy;

  int mismatch_total;
  int results_pending;
  bit quiet;
  bit hold_armed;
  bit hold_done;
  int idle_cycles;

  always #5 clk = ~clk;

  max_priority_queue_array_unit #(.DEPTH(DEPTH)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_proc_id      (in_proc_id),
    .in_priority_req (in_priority_req),
    .in_burst_time   (in_burst_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_proc_id     (out_proc_id),
    .out_priority    (out_priority),
    .out_burst_time  (out_burst_time),
    .out_occupancy   (out_occupancy)
  );

  mpq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_proc_id      (in_proc_id),
    .in_priority_req (in_priority_req),
    .in_burst_time   (in_burst_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_proc_id     (out_proc_id),
    .out_priority    (out_priority),
    .out_burst_time  (out_burst_time),
    .out_occupancy   (out_occupancy),
    .mismatch_count  (mismatch_total),
    .results_pending (results_pending)
  );

  task automatic offer_request(input req_mode_t mode, input logic [ID_W-1:0] id,
                               input logic [PRIO_W-1:0] prio,
                               input logic [BURST_W-1:0] burst);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_mode         = mode;
    in_proc_id      = id;
    in_priority_req = prio;
    in_burst_time   = burst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random stall, one long hold-off once armed
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall = !quiet && ($urandom_range(99) < 15);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int                 n;
    int                 bias;
    req_mode_t          mode;
    logic [PRIO_W-1:0]  prio;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = MODE_INSERT;
    in_proc_id      = '0;
    in_priority_req = '0;
    in_burst_time   = '0;
    quiet           = 1'b0;
    hold_armed      = 1'b0;
    bias            = 50;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // underflow on empty, fill with extremes and ties, overflow, drain
    offer_request(MODE_REMOVE, 16'hFFFF, 8'hFF, 16'hFFFF);
    offer_request(MODE_INSERT, 16'h0000, 8'h00, 16'h0000);
    offer_request(MODE_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF);
    offer_request(MODE_INSERT, 16'h1234, 8'h80, 16'h5555);
    offer_request(MODE_INSERT, 16'hAAAA, 8'hFF, 16'h0001);
    offer_request(MODE_INSERT, 16'h5555, 8'h00, 16'hFFFF);
    offer_request(MODE_INSERT, 16'h0F0F, 8'h80, 16'hF0F0);
    offer_request(MODE_INSERT, 16'hFFFF, 8'h7F, 16'h0000);
    offer_request(MODE_INSERT, 16'h0001, 8'hFF, 16'h8000);
    offer_request(MODE_INSERT, 16'hDEAD, 8'hFF, 16'hBEEF);
    offer_request(MODE_INSERT, 16'h0000, 8'h00, 16'h0000);
    offer_request(MODE_REMOVE, 16'h0000, 8'h00, 16'h0000);
    offer_request(MODE_INSERT, 16'h7777, 8'hFF, 16'h7777);
    repeat (8) offer_request(MODE_REMOVE, 16'($urandom), 8'($urandom), 16'($urandom));
    offer_request(MODE_REMOVE, 16'hFFFF, 8'hFF, 16'hFFFF);
    offer_request(MODE_INSERT, 16'h8001, 8'h01, 16'h8001);
    offer_request(MODE_REMOVE, 16'h0000, 8'h00, 16'h0000);

    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0: bias = 25;
          1: bias = 50;
          default: bias = 80;
        endcase
      end
      quiet = (n >= 600 && n < 900);
      if (n == 200) hold_armed = 1'b1;
      mode = ($urandom_range(99) < bias) ? MODE_INSERT : MODE_REMOVE;
      case ($urandom_range(3))
        0: prio = 8'($urandom_range(3));
        1: prio = $urandom_range(1) ? 8'hFF : 8'h00;
        default: prio = 8'($urandom);
      endcase
      offer_request(mode, 16'($urandom), prio, 16'($urandom));
    end
    in_valid = 1'b0;

    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
